// ----- hw/rtl/polygon_area_aggregator_core_defines.svh -----
// Assertion macros shared by the polygon area aggregator RTL.
// No dependencies; the asserting modules must provide clk and rst_n.
`ifndef POLYGON_AREA_AGGREGATOR_CORE_DEFINES_SVH
`define POLYGON_AREA_AGGREGATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset only.
`define PAA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PAA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PAA_ASSERT(lbl, prop, msg)
`define PAA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/paa_pkg.sv -----
// Shared constants, aggregation mode codes and controller/datapath types
// for the polygon area aggregator. No dependencies.
package paa_pkg;

  localparam int COORD_BITS    = 16;
  localparam int PROD_BITS     = 2 * COORD_BITS;
  localparam int VTX_BITS      = 9;
  localparam int MAX_VERTICES  = 256;
  localparam int TALLY_BITS    = 13;
  localparam int CROSS_BITS    = 42;
  localparam int AREA_BITS     = 34;
  localparam int SUM_BITS      = 46;
  localparam int IN_DATA_BITS  = 2 * COORD_BITS;
  localparam int OUT_DATA_BITS = 48;
  localparam int CFG_DATA_BITS = 9;
  localparam int MODE_BITS     = 4;

  localparam logic [MODE_BITS-1:0] MODE_EVEN_SUM    = 4'd0;
  localparam logic [MODE_BITS-1:0] MODE_ODD_SUM     = 4'd1;
  localparam logic [MODE_BITS-1:0] MODE_MEAN        = 4'd2;
  localparam logic [MODE_BITS-1:0] MODE_EXACT_SUM   = 4'd3;
  localparam logic [MODE_BITS-1:0] MODE_MAX_AREA    = 4'd4;
  localparam logic [MODE_BITS-1:0] MODE_MIN_AREA    = 4'd5;
  localparam logic [MODE_BITS-1:0] MODE_MAX_VTX     = 4'd6;
  localparam logic [MODE_BITS-1:0] MODE_MIN_VTX     = 4'd7;
  localparam logic [MODE_BITS-1:0] MODE_EVEN_COUNT  = 4'd8;
  localparam logic [MODE_BITS-1:0] MODE_ODD_COUNT   = 4'd9;
  localparam logic [MODE_BITS-1:0] MODE_EXACT_COUNT = 4'd10;

  localparam logic CFG_IDX_MODE   = 1'b0;
  localparam logic CFG_IDX_TARGET = 1'b1;

  localparam logic [VTX_BITS-1:0] MIN_POLY_VTX = 9'd3;

  typedef struct packed {
    logic cap;        // latch the input request
    logic mul;        // register the two cross products
    logic sel_close;  // products against the first vertex
    logic acc;        // add the edge term into the running cross sum
    logic close;      // add the closing term and form the area
    logic fold;       // fold the finished polygon into the aggregate
    logic eos;        // evaluate the end-of-set result
    logic div_start;  // load the divider for the mean
    logic div_step;   // one quotient bit
    logic emit;       // load the output register and clear the set
  } paa_cmd_t;

  typedef struct packed {
    logic is_eos;
    logic last;
    logic need_div;
    logic div_busy;
  } paa_status_t;

endpackage

// ----- hw/rtl/paa_datapath.sv -----
// Datapath of the polygon area aggregator: vertex registers, cross product
// accumulator, aggregate state, mean divider and output payload. Uses paa_pkg.
module paa_datapath
  import paa_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  paa_cmd_t                     cmd,
  output paa_status_t                  sts,
  input  logic                         in_req,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic                         in_last,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_wdata,
  output logic [SUM_BITS-1:0]          out_result,
  output logic                         out_error
);

  localparam int WIDE_BITS    = CROSS_BITS + 2;
  localparam int TERM_BITS    = PROD_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

  localparam logic signed [WIDE_BITS-1:0] CROSS_HI =
    (WIDE_BITS'(1) <<< (CROSS_BITS - 1)) - WIDE_BITS'(1);
  localparam logic signed [WIDE_BITS-1:0] CROSS_LO = -CROSS_HI;
  localparam logic [CROSS_BITS-1:0] AREA_MAX =
    (CROSS_BITS'(1) << AREA_BITS) - CROSS_BITS'(1);
  localparam logic [SUM_BITS:0] SUM_MAX =
    (SUM_BITS+1)'((SUM_BITS+1)'(1) << SUM_BITS) - (SUM_BITS+1)'(1);
  localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};
  localparam logic [VTX_BITS-1:0] VTX_FULL = VTX_BITS'(MAX_VERTICES);

  function automatic logic signed [CROSS_BITS-1:0] clamp_cross(
    input logic signed [WIDE_BITS-1:0] v
  );
    logic signed [WIDE_BITS-1:0] c;
    begin
      c = v;
      if (v > CROSS_HI) c = CROSS_HI;
      else if (v < CROSS_LO) c = CROSS_LO;
      return c[CROSS_BITS-1:0];
    end
  endfunction

  // Configuration
  logic [MODE_BITS-1:0]     mode_r;
  logic [VTX_BITS-1:0]      target_r;

  // Current request and vertex state
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r;
  logic                         last_r, eos_r;
  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [PROD_BITS-1:0]  p_r, q_r;
  logic signed [CROSS_BITS-1:0] cross_r;
  logic [VTX_BITS-1:0]          vtx_r;
  logic [AREA_BITS-1:0]         area_r;

  // Set aggregate
  logic [SUM_BITS-1:0]   agg_r;
  logic [AREA_BITS-1:0]  best_r;
  logic [TALLY_BITS-1:0] poly_r;
  logic [TALLY_BITS-1:0] match_r;

  // Result and divider
  logic [SUM_BITS-1:0]     res_r;
  logic                    err_r;
  logic                    use_div_r;
  logic [SUM_BITS-1:0]     div_q_r;
  logic [TALLY_BITS-1:0]   div_rem_r;
  logic [DIV_CNT_BITS-1:0] div_cnt_r;
  logic [SUM_BITS-1:0]     out_result_r;
  logic                    out_error_r;

  logic signed [COORD_BITS-1:0] bx, by;
  logic signed [TERM_BITS-1:0]  term;
  logic signed [CROSS_BITS-1:0] cross_new;
  logic [CROSS_BITS-1:0]        mag;
  logic                         even, exact, empty, tgt_small;
  logic [SUM_BITS:0]            sum_wide;
  logic [AREA_BITS-1:0]         nv_ext;
  logic [SUM_BITS-1:0]          eos_val;
  logic                         eos_err;
  logic [TALLY_BITS:0]          rem_sh, rem_sub;
  logic                         rem_ge;

  assign bx = cmd.sel_close ? first_x_r : cur_x_r;
  assign by = cmd.sel_close ? first_y_r : cur_y_r;

  assign term = {p_r[PROD_BITS-1], p_r} - {q_r[PROD_BITS-1], q_r};
  assign cross_new = clamp_cross({{2{cross_r[CROSS_BITS-1]}}, cross_r}
                     + {{(WIDE_BITS-TERM_BITS){term[TERM_BITS-1]}}, term});
  assign mag = cross_new[CROSS_BITS-1] ? CROSS_BITS'(-cross_new) : CROSS_BITS'(cross_new);

  assign even      = ~vtx_r[0];
  assign exact     = (vtx_r == target_r);
  assign empty     = (poly_r == '0);
  assign tgt_small = (target_r < MIN_POLY_VTX);
  assign sum_wide  = {1'b0, agg_r} + (SUM_BITS+1)'(area_r);
  assign nv_ext    = AREA_BITS'(vtx_r);

  // One restoring division step; the remainder always stays below the divisor.
  assign rem_sh  = {div_rem_r, div_q_r[SUM_BITS-1]};
  assign rem_ge  = (rem_sh >= {1'b0, poly_r});
  assign rem_sub = rem_sh - {1'b0, poly_r};

  always_comb begin
    eos_val = '0;
    eos_err = 1'b0;
    unique case (mode_r)
      MODE_EVEN_SUM, MODE_ODD_SUM: eos_val = agg_r;
      MODE_MEAN:                   eos_err = empty;
      MODE_EXACT_SUM: begin
        eos_err = tgt_small;
        eos_val = agg_r;
      end
      MODE_MAX_AREA, MODE_MIN_AREA, MODE_MAX_VTX, MODE_MIN_VTX: begin
        eos_err = empty;
        eos_val = SUM_BITS'(best_r);
      end
      MODE_EVEN_COUNT, MODE_ODD_COUNT: eos_val = SUM_BITS'(match_r);
      MODE_EXACT_COUNT: begin
        eos_err = tgt_small;
        eos_val = SUM_BITS'(match_r);
      end
      default: eos_err = 1'b1;
    endcase
    if (eos_err) eos_val = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_EVEN_SUM;
      target_r  <= MIN_POLY_VTX;
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      cross_r   <= '0;
      vtx_r     <= '0;
      agg_r     <= '0;
      best_r    <= '0;
      poly_r    <= '0;
      match_r   <= '0;
      div_cnt_r <= '0;
      use_div_r <= 1'b0;
      eos_r     <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_MODE) mode_r <= cfg_wdata[MODE_BITS-1:0];
        else                           target_r <= cfg_wdata;
      end

      if (cmd.cap) begin
        eos_r   <= in_req;
        last_r  <= in_last;
        cur_x_r <= in_x;
        cur_y_r <= in_y;
      end

      if (cmd.mul) begin
        p_r <= prev_x_r * by;
        q_r <= prev_y_r * bx;
      end

      if (cmd.acc) begin
        if (vtx_r == '0) begin
          first_x_r <= cur_x_r;
          first_y_r <= cur_y_r;
          prev_x_r  <= cur_x_r;
          prev_y_r  <= cur_y_r;
          cross_r   <= '0;
          vtx_r     <= VTX_BITS'(1);
        end else if (vtx_r < VTX_FULL) begin
          cross_r  <= cross_new;
          prev_x_r <= cur_x_r;
          prev_y_r <= cur_y_r;
          vtx_r    <= vtx_r + VTX_BITS'(1);
        end
      end

      if (cmd.close) begin
        area_r <= (mag > AREA_MAX) ? AREA_MAX[AREA_BITS-1:0] : mag[AREA_BITS-1:0];
      end

      if (cmd.fold) begin
        if (vtx_r >= MIN_POLY_VTX) begin
          unique case (mode_r)
            MODE_EVEN_SUM, MODE_ODD_SUM, MODE_MEAN, MODE_EXACT_SUM: begin
              if ((mode_r == MODE_MEAN) || (mode_r == MODE_EVEN_SUM && even) ||
                  (mode_r == MODE_ODD_SUM && !even) || (mode_r == MODE_EXACT_SUM && exact))
                agg_r <= (sum_wide > SUM_MAX) ? SUM_MAX[SUM_BITS-1:0]
                                              : sum_wide[SUM_BITS-1:0];
            end
            MODE_MAX_AREA: if (empty || area_r > best_r) best_r <= area_r;
            MODE_MIN_AREA: if (empty || area_r < best_r) best_r <= area_r;
            MODE_MAX_VTX:  if (empty || nv_ext > best_r) best_r <= nv_ext;
            MODE_MIN_VTX:  if (empty || nv_ext < best_r) best_r <= nv_ext;
            MODE_EVEN_COUNT, MODE_ODD_COUNT, MODE_EXACT_COUNT: begin
              if (match_r != TALLY_MAX &&
                  ((mode_r == MODE_EVEN_COUNT && even) ||
                   (mode_r == MODE_ODD_COUNT && !even) ||
                   (mode_r == MODE_EXACT_COUNT && exact)))
                match_r <= match_r + TALLY_BITS'(1);
            end
            default: ;
          endcase
          if (poly_r != TALLY_MAX) poly_r <= poly_r + TALLY_BITS'(1);
        end
        vtx_r   <= '0;
        cross_r <= '0;
      end

      if (cmd.eos) begin
        res_r     <= eos_val;
        err_r     <= eos_err;
        use_div_r <= sts.need_div;
      end

      if (cmd.div_start) begin
        div_q_r   <= agg_r;
        div_rem_r <= '0;
        div_cnt_r <= DIV_CNT_BITS'(SUM_BITS);
      end else if (cmd.div_step) begin
        div_q_r   <= {div_q_r[SUM_BITS-2:0], rem_ge};
        div_rem_r <= rem_ge ? rem_sub[TALLY_BITS-1:0] : rem_sh[TALLY_BITS-1:0];
        div_cnt_r <= div_cnt_r - DIV_CNT_BITS'(1);
      end

      if (cmd.emit) begin
        out_result_r <= use_div_r ? div_q_r : res_r;
        out_error_r  <= err_r;
        // The end of a set also drops any unfinished polygon.
        vtx_r   <= '0;
        cross_r <= '0;
        agg_r   <= '0;
        best_r  <= '0;
        poly_r  <= '0;
        match_r <= '0;
      end
    end
  end

  assign sts.is_eos   = eos_r;
  assign sts.last     = last_r;
  assign sts.need_div = (mode_r == MODE_MEAN) && !empty;
  assign sts.div_busy = (div_cnt_r != '0);

  assign out_result = out_result_r;
  assign out_error  = out_error_r;

endmodule

// ----- hw/rtl/paa_controller.sv -----
// Sequencing state machine of the polygon area aggregator: input handshake,
// datapath commands and the output valid flag. Uses paa_pkg and the defines header.
`include "polygon_area_aggregator_core_defines.svh"
module paa_controller
  import paa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  paa_status_t sts,
  output paa_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ACC, S_CMUL, S_CLOSE, S_FOLD, S_DIV, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts.is_eos) begin
          cmd.eos       = 1'b1;
          cmd.div_start = sts.need_div;
          state_nxt     = sts.need_div ? S_DIV : S_EMIT;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last ? S_CMUL : S_IDLE;
      end
      S_CMUL: begin
        cmd.mul       = 1'b1;
        cmd.sel_close = 1'b1;
        state_nxt     = S_CLOSE;
      end
      S_CLOSE: begin
        cmd.close = 1'b1;
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DIV: begin
        if (sts.div_busy) cmd.div_step = 1'b1;
        else              state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // The result waits here until the output register is free.
        if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PAA_ASSERT(a_emit_slot_free, (cmd.emit |-> (!out_valid_r || out_tready)), "emit into a full output register")
  `PAA_ASSERT(a_step_only_busy, (cmd.div_step |-> sts.div_busy), "divider stepped past its last bit")
  `PAA_ASSERT(a_accept_loads, ((in_tvalid && in_tready) |=> (state_r == S_LOAD)), "accepted request not loaded")
  `PAA_ASSERT(a_last_closes, ((state_r == S_ACC && sts.last) |=> (state_r == S_CMUL)), "last vertex did not start the closing edge")
  `PAA_ASSERT_ALWAYS(a_reset_idle, (!rst_n |=> (state_r == S_IDLE && !out_valid_r)), "reset did not return to idle")

endmodule

// ----- hw/rtl/polygon_area_aggregator_core.sv -----
// Polygon area aggregator: shoelace doubled areas folded into a per-set result.
// Top level; instantiates paa_controller and paa_datapath, uses paa_pkg.
//
// Usage:
//   The input stream carries one request per beat. in_tuser low: a vertex,
//   with x in in_tdata[15:0], y in in_tdata[31:16] and in_tlast marking the
//   final vertex of a polygon. in_tuser high: end of set; one result follows.
//   The result stream returns the value in out_tdata[45:0] and the error flag
//   in out_tuser. The cfg port writes agg_mode (index 0) and target_vertices
//   (index 1); the user must write them only while the block is idle, and
//   the block itself does not enforce it; writes do not clear the aggregate.
//   A vertex takes capture, multiply and accumulate steps; a closing vertex
//   adds a closing multiply on the shared cross product multiplier pair, a
//   close and the fold step. For a non-empty set in the mean mode, the end-of-set
//   result waits on the bit-serial divider, one quotient bit a cycle. The output
//   register lets vertex requests proceed while a result waits; a further
//   end-of-set request is accepted, but the block then stalls until that result
//   has been taken. Reset returns the block to idle with an empty set, agg_mode 0
//   and target_vertices 3.
module polygon_area_aggregator_core
  import paa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // vertex_x [15:0], vertex_y [31:16]
  input  logic                     in_tuser,   // req_type
  input  logic                     in_tlast,   // last_vertex
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // result_value [45:0], zero [47:46]
  output logic                     out_tuser,  // error_flag
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  paa_cmd_t            cmd;
  paa_status_t         sts;
  logic [SUM_BITS-1:0] result;

  paa_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  paa_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_req     (in_tuser),
    .in_x       (in_tdata[COORD_BITS-1:0]),
    .in_y       (in_tdata[IN_DATA_BITS-1:COORD_BITS]),
    .in_last    (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_result (result),
    .out_error  (out_tuser)
  );

  assign out_tdata = {{(OUT_DATA_BITS-SUM_BITS){1'b0}}, result};

endmodule
